@@ src/assert_macros.svh @@
// Assertion macros shared by the cache RTL modules.
// Both macros sample on posedge clk; the first one is gated by rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every edge, including while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/lkvc_pkg.sv @@
// Shared types and constants for the LRU key/value cache.
// Used by lkvc_ctrl, lkvc_dpath and lru_key_value_cache_core.
package lkvc_pkg;

  localparam int CFG_W = 5;
  localparam int OCC_W = 5;
  localparam logic [CFG_W-1:0] MAX_SIZE_RESET = 5'd16;

  localparam logic [1:0] OP_GET   = 2'd0;
  localparam logic [1:0] OP_PUT   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [63:0] lookup_key;
    logic signed [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic [OCC_W-1:0]   occupancy;
  } res_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic scan;
    logic decide;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_update;
    logic res_free;
  } stat_t;

endpackage

@@ src/lkvc_ctrl.sv @@
// Sequencer for the cache: idle, lookup sweep, decision, rank sweep, result.
// Depends on lkvc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lkvc_ctrl import lkvc_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic [1:0]    req_op,
  output logic          req_stall,
  output cmd_t          cmd,
  output logic [AW-1:0] rd_addr,
  input  stat_t         stat
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic [CW-1:0] LAST = CW'(CAPACITY);

  logic [2:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = req_valid;
        cnt_next = '0;
        if (req_valid) begin
          state_next = (req_op == OP_GET || req_op == OP_PUT) ? S_SCAN : S_DECIDE;
        end
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        cmd.rd_en = (cnt != LAST);
        cnt_next  = CW'(cnt + 1'b1);
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        cnt_next   = '0;
        state_next = stat.need_update ? S_UPDATE : S_FINISH;
      end
      S_UPDATE: begin
        cmd.rd_en = (cnt != LAST);
        cnt_next  = CW'(cnt + 1'b1);
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        if (stat.res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign req_stall = (state != S_IDLE);
  assign rd_addr   = cnt[AW-1:0];

  `ASSERT_CLK_RST(a_cmd_exclusive, $onehot0({cmd.load, cmd.rd_en, cmd.decide, cmd.finish}),
    "controller issued overlapping commands")
  `ASSERT_CLK_RST(a_scan_to_decide, (state == S_SCAN && cnt == LAST) |=> (state == S_DECIDE),
    "lookup sweep did not end in the decision step")

endmodule

@@ src/lkvc_dpath.sv @@
// Datapath of the cache: key/value/rank memories, valid bits, count,
// sweep compare logic, limit register and result register. Uses lkvc_pkg.
`include "assert_macros.svh"

module lkvc_dpath import lkvc_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  cmd_t             cmd,
  input  logic [AW-1:0]    rd_addr,
  output stat_t            stat,
  output logic             res_valid,
  input  logic             res_stall,
  output res_t             res
);

  logic [63:0]        key_mem   [CAPACITY];
  logic [31:0]        value_mem [CAPACITY];
  logic [AW-1:0]      rank_mem  [CAPACITY];

  logic [CAPACITY-1:0] valid_bits, valid_next;
  logic [CW-1:0]       count, count_next;
  logic [CFG_W-1:0]    max_size;
  req_t                req_q;

  logic [63:0]   key_q;
  logic [31:0]   value_q;
  logic [AW-1:0] rank_q;
  logic [AW-1:0] rd_idx;
  logic          rd_vld, rd_scan;

  logic          have_match, have_max, have_free;
  logic [AW-1:0] match_idx, max_idx, free_idx;
  logic [AW-1:0] match_rank, max_rank;
  logic [31:0]   match_value;

  logic [AW-1:0] slot, slot_d;
  logic [AW-1:0] thresh, thresh_d;
  logic          inc_all, inc_all_d;
  logic          need_upd, key_we, val_we;
  logic          hit_d;
  logic [31:0]   rdval_d;
  res_t          res_stage;

  logic [CFG_W-1:0] eff_limit;
  logic             full;
  logic             entry_on;

  // read port, one entry per cycle during either sweep
  always_ff @(posedge clk) begin
    key_q   <= key_mem[rd_addr];
    value_q <= value_mem[rd_addr];
    rank_q  <= rank_mem[rd_addr];
    rd_idx  <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      rd_scan <= 1'b0;
    end else begin
      rd_vld  <= cmd.rd_en;
      rd_scan <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[slot_d] <= req_q.lookup_key;
    end
    if (val_we) begin
      value_mem[slot_d] <= req_q.write_value;
    end
  end

  assign entry_on = valid_bits[rd_idx];

  // rank write-back during the second sweep
  always_ff @(posedge clk) begin
    if (rd_vld && !rd_scan) begin
      if (rd_idx == slot) begin
        rank_mem[rd_idx] <= '0;
      end else if (entry_on && (inc_all || rank_q < thresh)) begin
        rank_mem[rd_idx] <= AW'(rank_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  // lookup sweep: first match, oldest valid entry, first free entry
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      have_match <= 1'b0;
      have_max   <= 1'b0;
      have_free  <= 1'b0;
    end else if (rd_vld && rd_scan) begin
      if (entry_on && !have_match && key_q == req_q.lookup_key) begin
        have_match <= 1'b1;
      end
      if (entry_on && (!have_max || rank_q > max_rank)) begin
        have_max <= 1'b1;
      end
      if (!entry_on && !have_free) begin
        have_free <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && rd_scan) begin
      if (entry_on && !have_match && key_q == req_q.lookup_key) begin
        match_idx   <= rd_idx;
        match_rank  <= rank_q;
        match_value <= value_q;
      end
      if (entry_on && (!have_max || rank_q > max_rank)) begin
        max_idx  <= rd_idx;
        max_rank <= rank_q;
      end
      if (!entry_on && !have_free) begin
        free_idx <= rd_idx;
      end
    end
  end

  assign eff_limit = (max_size == '0) ? CFG_W'(1) : max_size;
  assign full = (CMP_W'(count) >= CMP_W'(eff_limit)) || (CMP_W'(count) >= CMP_W'(CAPACITY));

  always_comb begin
    hit_d      = 1'b0;
    rdval_d    = '0;
    need_upd   = 1'b0;
    slot_d     = match_idx;
    thresh_d   = match_rank;
    inc_all_d  = 1'b0;
    key_we     = 1'b0;
    val_we     = 1'b0;
    valid_next = valid_bits;
    count_next = count;
    if (cmd.decide) begin
      case (req_q.operation)
        OP_GET: begin
          if (have_match) begin
            hit_d    = 1'b1;
            rdval_d  = match_value;
            need_upd = 1'b1;
          end
        end
        OP_PUT: begin
          if (have_match) begin
            hit_d    = 1'b1;
            val_we   = 1'b1;
            need_upd = 1'b1;
          end else if (full && have_max) begin
            slot_d    = max_idx;
            inc_all_d = 1'b1;
            key_we    = 1'b1;
            val_we    = 1'b1;
            need_upd  = 1'b1;
          end else if (have_free) begin
            slot_d             = free_idx;
            inc_all_d          = 1'b1;
            key_we             = 1'b1;
            val_we             = 1'b1;
            need_upd           = 1'b1;
            valid_next[free_idx] = 1'b1;
            count_next         = CW'(count + 1'b1);
          end
        end
        OP_CLEAR: begin
          valid_next = '0;
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      count      <= '0;
      max_size   <= MAX_SIZE_RESET;
    end else begin
      valid_bits <= valid_next;
      count      <= count_next;
      if (cfg_we) begin
        max_size <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      slot                 <= slot_d;
      thresh               <= thresh_d;
      inc_all              <= inc_all_d;
      res_stage.hit        <= hit_d;
      res_stage.read_value <= rdval_d;
      res_stage.occupancy  <= OCC_W'(count_next);
    end
  end

  assign stat.need_update = need_upd;
  assign stat.res_free    = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish && stat.res_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && stat.res_free) begin
      res <= res_stage;
    end
  end

  `ASSERT_CLK_RST(a_count_bound, CMP_W'(count) <= CMP_W'(CAPACITY),
    "entry count above capacity")
  `ASSERT_CLK_RST(a_count_matches_valid, $countones(valid_bits) == int'(count),
    "entry count out of step with valid bits")

endmodule

@@ src/lru_key_value_cache_core.sv @@
// Top level of the fully associative LRU key/value cache.
// Joins lkvc_ctrl and lkvc_dpath; types from lkvc_pkg.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------
//  request  | req_valid / req_stall  | req (operation, key, value)
//  result   | res_valid / res_stall  | res (hit, read_value, occupancy)
//  config   | cfg_we                 | cfg_wdata (max_size)
//
// get/put: one sweep over the single-port key/value/rank memories for
//   lookup, one for rank update.
// get miss: lookup sweep only; clear and unused codes: no sweep.
// Reset (rst, synchronous) empties the table and sets max_size to 16.
// A finished result waits in the output register while res_stall is high;
//   the next request is taken once that register is loaded.
module lru_key_value_cache_core import lkvc_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             res_valid,
  input  logic             res_stall,
  output res_t             res,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  cmd_t          cmd;
  stat_t         stat;
  logic [AW-1:0] rd_addr;

  lkvc_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req.operation),
    .req_stall (req_stall),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .stat      (stat)
  );

  lkvc_dpath #(
    .CAPACITY(CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .stat      (stat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

@@ verif/lru_key_value_cache_core_tb.sv @@
// Self-checking testbench for lru_key_value_cache_core: directed table, then random phases.
// An LRU model predicts results not fixed in the table; depends only on lkvc_pkg, core RTL.
module lru_key_value_cache_core_tb import lkvc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 192;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [63:0] KEY_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] KEY_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;

  typedef struct {
    bit         is_cfg;
    logic [4:0] cfg;
    req_t       rq;
    bit         known;
    res_t       want;
  } plan_row_t;

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  req_t             req;
  logic             res_valid;
  logic             res_stall;
  res_t             res;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // Cache shadow state
  logic [63:0] key_mem [SLOTS];
  logic [31:0] val_mem [SLOTS];
  bit          live [SLOTS];
  int unsigned age [SLOTS];
  int unsigned fill;
  logic [4:0]  size_reg;

  res_t pending_results [$];
  int   n_errors = 0;
  int   n_requests;
  int   n_results = 0;
  int   n_hits;
  int   n_evicts;
  int   n_clears;
  int   n_cfg;
  int   cycles = 0;
  bit   tx_quiet;
  bit   rx_quiet;

  lru_key_value_cache_core #(.CAPACITY(SLOTS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic note_mismatch(input string what);
    n_errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic int idle_len();
    int unsigned u;
    u = $urandom_range(0, 99);
    if (u < 45) return 0;
    if (u < 85) return $urandom_range(1, 3);
    if (u < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned eff_limit();
    if (size_reg == 5'd0) return 1;
    if (size_reg > SLOTS) return SLOTS;
    return 32'(size_reg);
  endfunction

  function automatic void make_newest(input int idx);
    for (int i = 0; i < SLOTS; i++)
      if (live[i] && age[i] < age[idx]) age[i]++;
    age[idx] = 0;
  endfunction

  function automatic res_t cache_access(input req_t rq);
    res_t rs;
    int   hit_at;
    int   slot;
    rs = '0;
    hit_at = -1;
    if (rq.operation == OP_GET || rq.operation == OP_PUT)
      for (int i = 0; i < SLOTS; i++)
        if (hit_at < 0 && live[i] && key_mem[i] == rq.lookup_key) hit_at = i;
    case (rq.operation)
      OP_GET: begin
        if (hit_at >= 0) begin
          rs.hit = 1'b1;
          rs.read_value = val_mem[hit_at];
          make_newest(hit_at);
          n_hits++;
        end
      end
      OP_PUT: begin
        if (hit_at >= 0) begin
          rs.hit = 1'b1;
          val_mem[hit_at] = rq.write_value;
          make_newest(hit_at);
          n_hits++;
        end else begin
          slot = -1;
          if (fill >= eff_limit()) begin
            for (int i = 0; i < SLOTS; i++)
              if (live[i] && (slot < 0 || age[i] > age[slot])) slot = i;
            if (slot >= 0) begin
              live[slot] = 1'b0;
              fill--;
              n_evicts++;
            end
          end
          if (slot < 0)
            for (int i = 0; i < SLOTS; i++)
              if (slot < 0 && !live[i]) slot = i;
          if (slot >= 0) begin
            for (int i = 0; i < SLOTS; i++)
              if (live[i]) age[i]++;
            key_mem[slot] = rq.lookup_key;
            val_mem[slot] = rq.write_value;
            live[slot] = 1'b1;
            age[slot] = 0;
            fill++;
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          live[i] = 1'b0;
          age[i] = 0;
        end
        fill = 0;
        n_clears++;
      end
      default: ;
    endcase
    rs.occupancy = fill[4:0];
    return rs;
  endfunction

  // Called at an edge; returns at the edge where the request is taken.
  task automatic issue(input req_t rq, input res_t want);
    int gap;
    gap = tx_quiet ? 0 : idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= rq;
    req_valid <= 1'b1;
    pending_results.push_back(want);
    n_requests++;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_max_size(input logic [4:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_reg = v;
    n_cfg++;
  endtask

  function automatic plan_row_t req_row(input logic [1:0] op, input logic [63:0] key,
                                        input logic [31:0] val, input bit known = 1'b0,
                                        input bit h = 1'b0, input logic [31:0] rd = '0,
                                        input logic [4:0] occ = '0);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.cfg = '0;
    r.rq.operation = op;
    r.rq.lookup_key = key;
    r.rq.write_value = val;
    r.known = known;
    r.want.hit = h;
    r.want.read_value = rd;
    r.want.occupancy = occ;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [4:0] v);
    plan_row_t r;
    r = req_row(OP_UNUSED, '0, '0);
    r.is_cfg = 1'b1;
    r.cfg = v;
    return r;
  endfunction

  initial begin : result_monitor
    res_t want;
    int   stall_left;
    stall_left = 0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result hit %0b value %0d occupancy %0d",
                                  res.hit, res.read_value, res.occupancy));
        end else begin
          want = pending_results.pop_front();
          n_results++;
          if (res.hit !== want.hit)
            note_mismatch($sformatf("result %0d hit %b, want %b", n_results, res.hit,
                                    want.hit));
          if (res.read_value !== want.read_value)
            note_mismatch($sformatf("result %0d read_value %0d, want %0d", n_results,
                                    res.read_value, want.read_value));
          if (res.occupancy !== want.occupancy)
            note_mismatch($sformatf("result %0d occupancy %0d, want %0d", n_results,
                                    res.occupancy, want.occupancy));
        end
      end
      if (stall_left != 0) stall_left--;
      else if (!rx_quiet) stall_left = idle_len();
      res_stall <= (stall_left != 0);
    end
  end

  initial begin : stimulus
    plan_row_t   plan [$];
    logic [4:0]  phase_size [PHASES];
    logic [63:0] pool [$];
    logic [63:0] key;
    logic [31:0] val;
    logic [1:0]  op;
    req_t        rq;
    res_t        got;
    int unsigned u;
    int unsigned pool_n;

    n_requests = 0;
    n_hits = 0;
    n_evicts = 0;
    n_clears = 0;
    n_cfg = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    fill = 0;
    size_reg = MAX_SIZE_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      live[i] = 1'b0;
      age[i] = 0;
      key_mem[i] = '0;
      val_mem[i] = '0;
    end

    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: key/value extremes, every op, out-of-range and lowered limits
    plan.push_back(req_row(OP_GET,    64'd0,   32'd0,   1'b1, 1'b0, 32'd0,   5'd0));
    plan.push_back(req_row(OP_PUT,    KEY_MIN, VAL_MIN, 1'b1, 1'b0, 32'd0,   5'd1));
    plan.push_back(req_row(OP_PUT,    KEY_MAX, VAL_MAX, 1'b1, 1'b0, 32'd0,   5'd2));
    plan.push_back(req_row(OP_GET,    KEY_MIN, 32'd0,   1'b1, 1'b1, VAL_MIN, 5'd2));
    plan.push_back(req_row(OP_GET,    KEY_MAX, '1,      1'b1, 1'b1, VAL_MAX, 5'd2));
    plan.push_back(req_row(OP_PUT,    KEY_MAX, 32'd0,   1'b1, 1'b1, 32'd0,   5'd2));
    plan.push_back(req_row(OP_UNUSED, KEY_MIN, '1,      1'b1, 1'b0, 32'd0,   5'd2));
    plan.push_back(req_row(OP_GET,    '1,      32'd0,   1'b1, 1'b0, 32'd0,   5'd2));
    plan.push_back(req_row(OP_CLEAR,  KEY_MIN, VAL_MAX, 1'b1, 1'b0, 32'd0,   5'd0));
    plan.push_back(req_row(OP_GET,    KEY_MIN, 32'd0,   1'b1, 1'b0, 32'd0,   5'd0));
    plan.push_back(cfg_row(5'd0));
    plan.push_back(req_row(OP_PUT,    64'd5,   32'd5,   1'b1, 1'b0, 32'd0,   5'd1));
    plan.push_back(req_row(OP_PUT,    64'd6,   32'd6,   1'b1, 1'b0, 32'd0,   5'd1));
    plan.push_back(req_row(OP_GET,    64'd5,   32'd0,   1'b1, 1'b0, 32'd0,   5'd1));
    plan.push_back(req_row(OP_GET,    64'd6,   32'd0,   1'b1, 1'b1, 32'd6,   5'd1));
    plan.push_back(cfg_row(5'd3));
    plan.push_back(req_row(OP_PUT,    64'd7,   32'd7));
    plan.push_back(req_row(OP_PUT,    64'd8,   32'd8));
    plan.push_back(req_row(OP_GET,    64'd6,   32'd0));
    plan.push_back(req_row(OP_PUT,    64'd9,   32'd9));
    plan.push_back(req_row(OP_GET,    64'd7,   32'd0));
    plan.push_back(cfg_row(5'd1));
    plan.push_back(req_row(OP_PUT,    64'd10,  32'd10));
    plan.push_back(req_row(OP_GET,    64'd8,   32'd0));
    plan.push_back(req_row(OP_PUT,    64'd11,  '1));
    plan.push_back(cfg_row(5'd31));
    plan.push_back(req_row(OP_PUT,    64'd12,  32'd12));
    plan.push_back(req_row(OP_CLEAR,  '1,      '1));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_max_size(plan[i].cfg);
      end else begin
        got = cache_access(plan[i].rq);
        issue(plan[i].rq, plan[i].known ? plan[i].want : got);
      end
    end

    // Random phases; limits include both ends and out-of-range codes
    phase_size = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd2, 5'd16, 5'd8, 5'd24, 5'd5, 5'd3};
    phase_size[6] = 5'($urandom_range(0, 31));
    phase_size[8] = 5'($urandom_range(0, 31));
    for (int p = 0; p < PHASES; p++) begin
      set_max_size(phase_size[p]);
      u = $urandom_range(0, 3);
      tx_quiet = (u == 1 || u == 3);
      rx_quiet = (u == 2 || u == 3);
      pool.delete();
      pool_n = eff_limit() + $urandom_range(1, 5);
      for (int i = 0; i < pool_n; i++) begin
        if (i % 2 == 1) pool.push_back(pool[i-1] ^ (64'd1 << $urandom_range(0, 63)));
        else pool.push_back({$urandom, $urandom});
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_idle();
        u = $urandom_range(0, 99);
        if (u < 2) op = OP_CLEAR;
        else if (u < 5) op = OP_UNUSED;
        else if (u < 50) op = OP_GET;
        else op = OP_PUT;
        u = $urandom_range(0, 99);
        if (u < 85) key = pool[$urandom_range(0, pool_n - 1)];
        else if (u < 95) key = {$urandom, $urandom};
        else begin
          case ($urandom_range(0, 3))
            0: key = KEY_MIN;
            1: key = KEY_MAX;
            2: key = '0;
            default: key = '1;
          endcase
        end
        u = $urandom_range(0, 99);
        if (u < 3) val = VAL_MIN;
        else if (u < 6) val = VAL_MAX;
        else val = $urandom;
        rq.operation = op;
        rq.lookup_key = key;
        rq.write_value = val;
        got = cache_access(rq);
        issue(rq, got);
      end
    end

    wait_idle();
    repeat (60) @(posedge clk);
    $display("run: %0d requests, %0d results checked, %0d limit writes, %0d mismatches",
             n_requests, n_results, n_cfg, n_errors);
    $display("run: %0d hits, %0d evictions, %0d clears", n_hits, n_evicts, n_clears);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/lkvc_pkg.sv
src/lkvc_ctrl.sv
src/lkvc_dpath.sv
src/lru_key_value_cache_core.sv
verif/lru_key_value_cache_core_tb.sv
